// ===== rtl/aavr_pkg.sv =====
package aavr_pkg;

	localparam int VEC_W   = 24;
	localparam int AXIS_W  = 16;
	localparam int ANG_W   = 16;
	localparam int CORD_W  = 34;
	localparam int Z_W     = 34;
	localparam int TRIG_W  = 17;
	localparam int ATAN_LEN = 24;
	localparam int IN_W    = 3 * VEC_W + 3 * AXIS_W;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// members listed from the top bit down, so vec_x sits in the lowest bits
	typedef struct packed {
		logic signed [AXIS_W-1:0] axis_z;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [VEC_W-1:0]  vec_z;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_x;
	} side_t;

	function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			5'd0:  r = 34'sh020000000;
			5'd1:  r = 34'sh012E4051E;
			5'd2:  r = 34'sh009FB385B;
			5'd3:  r = 34'sh0051111D4;
			5'd4:  r = 34'sh0028B0D43;
			5'd5:  r = 34'sh00145D7E1;
			5'd6:  r = 34'sh000A2F61E;
			5'd7:  r = 34'sh000517C55;
			5'd8:  r = 34'sh00028BE53;
			5'd9:  r = 34'sh000145F2F;
			5'd10: r = 34'sh0000A2F98;
			5'd11: r = 34'sh0000517CC;
			5'd12: r = 34'sh000028BE6;
			5'd13: r = 34'sh0000145F3;
			5'd14: r = 34'sh00000A2FA;
			5'd15: r = 34'sh00000517D;
			5'd16: r = 34'sh0000028BE;
			5'd17: r = 34'sh00000145F;
			5'd18: r = 34'sh000000A30;
			5'd19: r = 34'sh000000518;
			5'd20: r = 34'sh00000028C;
			5'd21: r = 34'sh000000146;
			5'd22: r = 34'sh0000000A3;
			5'd23: r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/aavr_cordic_stage.sv =====
module aavr_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic signed [aavr_pkg::CORD_W-1:0] x_in,
	input  logic signed [aavr_pkg::CORD_W-1:0] y_in,
	input  logic signed [aavr_pkg::Z_W-1:0]    z_in,
	input  logic neg_in,
	input  aavr_pkg::side_t side_in,
	output logic vld_out,
	output logic signed [aavr_pkg::CORD_W-1:0] x_out,
	output logic signed [aavr_pkg::CORD_W-1:0] y_out,
	output logic signed [aavr_pkg::Z_W-1:0]    z_out,
	output logic neg_out,
	output aavr_pkg::side_t side_out
);
	import aavr_pkg::*;

	logic signed [CORD_W-1:0] xs, ys;
	logic signed [Z_W-1:0] at;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;
	assign at = atan_turn(5'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[Z_W-1]) begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - at;
			end else begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + at;
			end
			neg_out  <= neg_in;
			side_out <= side_in;
		end
	end
endmodule

// ===== rtl/aavr_matrix.sv =====
module aavr_matrix (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic signed [aavr_pkg::TRIG_W-1:0] cos_in,
	input  logic signed [aavr_pkg::TRIG_W-1:0] sin_in,
	input  aavr_pkg::side_t side_in,
	output logic vld_out,
	output logic signed [aavr_pkg::VEC_W-1:0] rot_x,
	output logic signed [aavr_pkg::VEC_W-1:0] rot_y,
	output logic signed [aavr_pkg::VEC_W-1:0] rot_z,
	output logic sat_out
);
	import aavr_pkg::*;

	// stage a: axis products and trig terms
	logic [2:0] vld_p;
	logic signed [32:0] sq_a [3];
	logic signed [32:0] pr_a [3];    // xy, xz, yz
	logic signed [33:0] as_a [3];    // a_k * s * 2^14 as a_k*s
	logic signed [TRIG_W-1:0] c_a;
	logic signed [TRIG_W:0] u_a;
	side_t sd_a;

	// stage b: entries in q.42 then rounded to q.28
	logic signed [35:0] m_b [9];
	side_t sd_b;
	// stage c: products
	logic signed [60:0] p_c [9];
	// stage d: sums and rounding
	logic signed [VEC_W-1:0] r_d [3];
	logic sat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= '0;
		end else if (en) begin
			vld_p <= {vld_p[1:0], vld_in};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_p[2];
	end

	logic signed [AXIS_W-1:0] ax [3];
	assign ax[0] = side_in.axis_x;
	assign ax[1] = side_in.axis_y;
	assign ax[2] = side_in.axis_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_a[i] <= 33'(ax[i] * ax[i]);
				as_a[i] <= 34'(ax[i] * sin_in);
			end
			pr_a[0] <= 33'(ax[0] * ax[1]);
			pr_a[1] <= 33'(ax[0] * ax[2]);
			pr_a[2] <= 33'(ax[1] * ax[2]);
			c_a  <= cos_in;
			u_a  <= 18'sd16384 - 18'(cos_in);
			sd_a <= side_in;
		end
	end

	function automatic logic signed [35:0] rnd14(input logic signed [53:0] m);
		logic signed [53:0] t;
		t = m + 54'sd8192;
		return 36'(t >>> 14);
	endfunction

	logic signed [33:0] dsq [3];   // 2^28 - a_i^2
	logic signed [50:0] dc [3];    // (2^28 - a_i^2) * cos
	logic signed [50:0] pu [3];    // a_i a_j * (1 - cos)
	logic signed [53:0] e [9];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsq[i] = 34'sd268435456 - 34'(sq_a[i]);
			dc[i] = dsq[i] * c_a;
			pu[i] = pr_a[i] * u_a;
			e[i*4] = (54'(sq_a[i]) <<< 14) + 54'(dc[i]);
		end
		e[1] = 54'(pu[0]) - (54'(as_a[2]) <<< 14);
		e[2] = 54'(pu[1]) + (54'(as_a[1]) <<< 14);
		e[3] = 54'(pu[0]) + (54'(as_a[2]) <<< 14);
		e[5] = 54'(pu[2]) - (54'(as_a[0]) <<< 14);
		e[6] = 54'(pu[1]) - (54'(as_a[1]) <<< 14);
		e[7] = 54'(pu[2]) + (54'(as_a[0]) <<< 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) m_b[k] <= rnd14(e[k]);
			sd_b <= sd_a;
		end
	end

	logic signed [VEC_W-1:0] vv [3];
	assign vv[0] = sd_b.vec_x;
	assign vv[1] = sd_b.vec_y;
	assign vv[2] = sd_b.vec_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) p_c[k] <= 61'(m_b[k] * vv[k % 3]);
		end
	end

	logic signed [62:0] acc [3];
	logic signed [62:0] rr [3];
	logic sat_c;
	logic signed [VEC_W-1:0] cl [3];
	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc[i] = 63'(p_c[3*i]) + 63'(p_c[3*i+1]) + 63'(p_c[3*i+2]) + 63'sd134217728;
			rr[i] = acc[i] >>> 28;
			if (rr[i] > 63'sd8388607) begin
				cl[i] = 24'sh7FFFFF; sat_c = 1'b1;
			end else if (rr[i] < -63'sd8388608) begin
				cl[i] = 24'sh800000; sat_c = 1'b1;
			end else begin
				cl[i] = rr[i][VEC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_d <= cl;
			sat_d <= sat_c;
		end
	end
	assign rot_x = r_d[0];
	assign rot_y = r_d[1];
	assign rot_z = r_d[2];
	assign sat_out = sat_d;
endmodule

// ===== rtl/axis_angle_vector_rotation.sv =====
// rodrigues axis-angle rotation of streamed 3d vectors
// throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or being taken, so a stall holds every stage
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
module axis_angle_vector_rotation #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vec_x[23:0], vec_y[47:24], vec_z[71:48], axis_x[87:72], axis_y[103:88],
	// axis_z[119:104], angle[135:120]
	input  logic [135:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// rot_x[23:0], rot_y[47:24], rot_z[71:48]
	output logic [71:0] m_axis_tdata,
	// saturated
	output logic m_axis_tuser
);
	import aavr_pkg::*;

	logic en;
	// pipeline advances whenever the output slot can take a new value
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// input stage: unpack and fold the angle into [-pi/2, pi/2)
	side_t sd_s1;
	logic vld_s1, neg_s1;
	logic signed [Z_W-1:0] z_s1;
	logic signed [ANG_W-1:0] ang;
	logic signed [ANG_W:0] angf;
	logic negf;
	assign ang = s_axis_tdata[135:120];
	always_comb begin
		if (ang >= 16'sd16384) begin
			angf = 17'(ang) - 17'sd32768; negf = 1'b1;
		end else if (ang < -16'sd16384) begin
			angf = 17'(ang) + 17'sd32768; negf = 1'b1;
		end else begin
			angf = 17'(ang); negf = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= Z_W'(angf) <<< 16;
			neg_s1 <= negf;
			sd_s1  <= s_axis_tdata[IN_W-1:0];
		end
	end

	// cordic chain, one iteration per stage
	logic vc [CORDIC_STAGES+1];
	logic signed [CORD_W-1:0] xc [CORDIC_STAGES+1];
	logic signed [CORD_W-1:0] yc [CORDIC_STAGES+1];
	logic signed [Z_W-1:0] zc [CORDIC_STAGES+1];
	logic nc [CORDIC_STAGES+1];
	side_t sc [CORDIC_STAGES+1];
	assign vc[0] = vld_s1;
	assign xc[0] = CORDIC_GAIN;
	assign yc[0] = '0;
	assign zc[0] = z_s1;
	assign nc[0] = neg_s1;
	assign sc[0] = sd_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		aavr_cordic_stage #(.IDX(g)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vc[g]), .x_in(xc[g]), .y_in(yc[g]), .z_in(zc[g]),
			.neg_in(nc[g]), .side_in(sc[g]),
			.vld_out(vc[g+1]), .x_out(xc[g+1]), .y_out(yc[g+1]), .z_out(zc[g+1]),
			.neg_out(nc[g+1]), .side_out(sc[g+1])
		);
	end

	// undo the fold and round cos/sin to q.14
	logic signed [CORD_W-1:0] xf, yf, xr, yr;
	logic signed [TRIG_W-1:0] cos_s2, sin_s2;
	logic vld_s2;
	side_t sd_s2;
	assign xf = nc[CORDIC_STAGES] ? -xc[CORDIC_STAGES] : xc[CORDIC_STAGES];
	assign yf = nc[CORDIC_STAGES] ? -yc[CORDIC_STAGES] : yc[CORDIC_STAGES];
	assign xr = (xf + 34'sd32768) >>> 16;
	assign yr = (yf + 34'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vc[CORDIC_STAGES];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s2 <= xr[TRIG_W-1:0];
			sin_s2 <= yr[TRIG_W-1:0];
			sd_s2  <= sc[CORDIC_STAGES];
		end
	end

	// matrix build and product, result lands in the output register
	logic signed [VEC_W-1:0] rx, ry, rz;
	logic sat;
	aavr_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2),
		.cos_in(cos_s2), .sin_in(sin_s2), .side_in(sd_s2),
		.vld_out(m_axis_tvalid), .rot_x(rx), .rot_y(ry), .rot_z(rz), .sat_out(sat)
	);
	assign m_axis_tdata = {rz, ry, rx};
	assign m_axis_tuser = sat;

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// no input taken while output stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted during stall");
	// folded angle stays within a quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (z_s1 >= -34'sd1073741824) && (z_s1 < 34'sd1073741824))
		else $error("angle fold out of range");
endmodule

// ===== tb/testbench.sv =====
module testbench;
	import aavr_pkg::*;

	// one rotation request, fields as they travel in s_axis_tdata
	typedef struct {
		logic signed [VEC_W-1:0]  v [3];
		logic signed [AXIS_W-1:0] a [3];
		logic signed [ANG_W-1:0]  ang;
	} rot_req_t;

	// one rotated vector plus its clip flag
	typedef struct {
		logic [VEC_W-1:0] r [3];
		logic             sat;
	} rot_res_t;

	localparam int STAGES  = 16;
	localparam int LATENCY = STAGES + 6;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tuser;

	rot_res_t expected_rot [$];
	int       error_count;
	int       sent_count;
	int       got_count;
	int       sat_count;
	bit       rx_stall_on;

	axis_angle_vector_rotation #(.CORDIC_STAGES(STAGES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	// floor division by 2^n, arithmetic shift on a signed 64-bit value
	function automatic longint fdiv(input longint x, input int n);
		return x >>> n;
	endfunction

	function automatic longint rshift_round(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// cordic sine/cosine in q.14 from a 16-bit binary angle
	function automatic void cordic_trig(input logic signed [ANG_W-1:0] ang_in,
			output longint c14, output longint s14);
		longint ang, x, y, z, nx, at;
		bit flip;
		ang = longint'(ang_in);
		flip = 0;
		x = 652032874;
		y = 0;
		if (ang >= 16384) begin
			ang -= 32768;
			flip = 1;
		end else if (ang < -16384) begin
			ang += 32768;
			flip = 1;
		end
		z = ang * 65536;
		for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
			at = longint'(atan_turn(5'(i)));
			if (z >= 0) begin
				nx = x - fdiv(y, i);
				y = y + fdiv(x, i);
				z -= at;
			end else begin
				nx = x + fdiv(y, i);
				y = y - fdiv(x, i);
				z += at;
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c14 = rshift_round(x, 16);
		s14 = rshift_round(y, 16);
	endfunction

	// rotated vector for one request
	function automatic rot_res_t rodrigues_rotate(input rot_req_t q);
		rot_res_t res;
		longint v [3], a [3], m [3][3];
		longint c, s, uct, acc, r, sq;
		v[0] = longint'(q.v[0]); v[1] = longint'(q.v[1]); v[2] = longint'(q.v[2]);
		a[0] = longint'(q.a[0]); a[1] = longint'(q.a[1]); a[2] = longint'(q.a[2]);
		cordic_trig(q.ang, c, s);
		uct = 16384 - c;
		for (int i = 0; i < 3; i++) begin
			sq = a[i] * a[i];
			m[i][i] = sq * 16384 + ((64'sd1 <<< 28) - sq) * c;
		end
		m[0][1] = a[0] * a[1] * uct - a[2] * s * 16384;
		m[0][2] = a[0] * a[2] * uct + a[1] * s * 16384;
		m[1][0] = a[0] * a[1] * uct + a[2] * s * 16384;
		m[1][2] = a[1] * a[2] * uct - a[0] * s * 16384;
		m[2][0] = a[0] * a[2] * uct - a[1] * s * 16384;
		m[2][1] = a[1] * a[2] * uct + a[0] * s * 16384;
		res.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += rshift_round(m[i][j], 14) * v[j];
			r = rshift_round(acc, 28);
			if (r > 8388607) begin
				r = 8388607;
				res.sat = 1'b1;
			end
			if (r < -8388608) begin
				r = -8388608;
				res.sat = 1'b1;
			end
			res.r[i] = r[VEC_W-1:0];
		end
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("mismatch %s at result %0d: got %0h expected %0h", what, got_count, got, want);
	endtask

	// send one transaction and queue its prediction on acceptance
	// valid stays high afterwards so the next one can follow without a gap
	task automatic send_rotation(input rot_req_t q, input bit with_gaps);
		int g;
		g = with_gaps ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {q.ang, q.a[2], q.a[1], q.a[0], q.v[2], q.v[1], q.v[0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_rot.push_back(rodrigues_rotate(q));
		sent_count++;
	endtask

	// output side: random backpressure while rx_stall_on is set, check each transaction
	initial begin
		rot_res_t w;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_rot.size() == 0) begin
					report_mismatch("unexpected", longint'(m_axis_tdata[63:0]), longint'(0));
				end else begin
					w = expected_rot.pop_front();
					for (int i = 0; i < 3; i++)
						if (m_axis_tdata[i*VEC_W +: VEC_W] !== w.r[i])
							report_mismatch($sformatf("rot[%0d]", i),
								longint'(m_axis_tdata[i*VEC_W +: VEC_W]),
								longint'(w.r[i]));
					if (m_axis_tuser !== w.sat)
						report_mismatch("saturated", longint'(m_axis_tuser), longint'(w.sat));
					if (w.sat) sat_count++;
				end
				got_count++;
			end
			m_axis_tready <= rx_stall_on ? ($urandom_range(0, 99) < 70) : 1'b1;
		end
	end

	function automatic rot_req_t make_req(input longint vx, vy, vz, ax, ay, az, an);
		rot_req_t q;
		q.v[0] = VEC_W'(vx); q.v[1] = VEC_W'(vy); q.v[2] = VEC_W'(vz);
		q.a[0] = AXIS_W'(ax); q.a[1] = AXIS_W'(ay); q.a[2] = AXIS_W'(az);
		q.ang = ANG_W'(an);
		return q;
	endfunction

	// drop valid, then wait until every queued result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_rot.size() != 0) @(posedge clk);
	endtask

	// axis extremes, principal angles, unit and non-unit axes, clipping
	task automatic test_directed();
		longint angs [8] = '{0, 16384, -16384, 16383, -16385, 32767, -32768, 8192};
		rx_stall_on = 0;
		foreach (angs[k])
			send_rotation(make_req(65536, -65536, 32768, 16384, 0, 0, angs[k]), 0);
		send_rotation(make_req(8388607, 8388607, 8388607, 16384, 16384, 16384, 5000), 0);
		send_rotation(make_req(-8388608, -8388608, -8388608, -16384, -16384, -16384,
			-7000), 0);
		send_rotation(make_req(8388607, -8388608, 0, 0, 0, 16384, 16384), 0);
		send_rotation(make_req(100, 200, 300, 32767, -32768, 12345, 1234), 0);
		send_rotation(make_req(-8388608, 8388607, -1, -32768, -32768, 32767, -32768), 0);
		send_rotation(make_req(65536, 65536, 65536, 9459, 9459, 9459, 10923), 0);
		send_rotation(make_req(0, 0, 0, 11585, -11585, 0, -12000), 0);
		send_rotation(make_req(1, -1, 1, 0, 16384, 0, 16384), 0);
		wait_drained();
	endtask

	// random vectors, mostly axes with components within +/-1.0 in q.14, some raw 16-bit axes
	task automatic test_random(input int n, input bit stalls);
		rot_req_t q;
		rx_stall_on = stalls;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) q.v[i] = VEC_W'($urandom());
			if ($urandom_range(0, 3) != 0)
				for (int i = 0; i < 3; i++) begin
					q.v[i] = $signed(q.v[i]) >>> $urandom_range(0, 8);
				end
			if ($urandom_range(0, 9) < 7) begin
				for (int i = 0; i < 3; i++)
					q.a[i] = AXIS_W'($urandom_range(0, 32768) - 16384);
			end else begin
				for (int i = 0; i < 3; i++) q.a[i] = AXIS_W'($urandom());
			end
			q.ang = ANG_W'($urandom());
			send_rotation(q, stalls);
			// hold off once midway until the pipeline empties
			if (k == n / 2) wait_drained();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		error_count = 0;
		sent_count = 0;
		got_count = 0;
		sat_count = 0;
		rx_stall_on = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 0);
		test_random(750, 1);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d rotations (%0d clipped), directed extremes and random stalls",
			got_count, sat_count);
		if (error_count == 0 && expected_rot.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
